[rtl/stkf_pkg.sv]
// Package with the round count, round-key table and round function of the seed-to-key transform.
package stkf_pkg;

    // Number of rounds, one cell per round.
    localparam int ROUNDS = 19;

    // Number of stored round keys; rounds beyond the table wrap round it.
    localparam int NUM_RKEYS = 19;

    // Width of one Feistel half.
    localparam int HALF_W = 16;

    typedef logic [HALF_W-1:0] half_t;

    // Fixed round keys, one per round.
    localparam half_t RKEY_TABLE [NUM_RKEYS] = '{
        16'hb5d5, 16'h1741, 16'hfe95, 16'h4ad5, 16'h9497, 16'hddc5, 16'h3761,
        16'h4b0d, 16'h5f5d, 16'h6b23, 16'hcfa9, 16'hc8e7, 16'hf209, 16'h4fff,
        16'hff2b, 16'h4801, 16'h8891, 16'h48b9, 16'h3607
    };

    // Round function: key mix, shift-in of a parity bit, byte swap, key mix again.
    function automatic half_t round_fn(input half_t lo, input half_t rkey);
        half_t t;
        half_t s;
        logic  p;
        t = lo ^ rkey;
        p = t[15] ^ t[4] ^ t[2] ^ t[1];
        s = {t[HALF_W-2:0], p};
        return {s[7:0], s[15:8]} ^ rkey;
    endfunction

endpackage

[rtl/stkf_cell.sv]
// One Feistel round cell: combines the halves with its round key and registers the result.
module stkf_cell
    import stkf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  valid_in,
    input  half_t hi_in,
    input  half_t lo_in,
    input  half_t rkey,
    output logic  valid_out,
    output half_t hi_out,
    output half_t lo_out
);

    logic  valid_reg;
    half_t hi_reg;
    half_t lo_reg;
    half_t hi_next;
    half_t lo_next;

    // The old high half moves down; the new high half takes the round function.
    always_comb
    begin
        lo_next = hi_in;
        hi_next = hi_in ^ round_fn(lo_in, rkey);
    end

    // Valid flag for the item held in this cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Half registers carry no reset; the valid flag qualifies them.
    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign valid_out = valid_reg;
    assign hi_out    = hi_reg;
    assign lo_out    = lo_reg;

endmodule

[rtl/seed_to_key_feistel.sv]
// Top level of the seed-to-key transform: a row of round cells, one per round.
// A seed transferred at a clock edge passes through the one register in each round cell in
// turn, and its key appears on key, with done high, at the tail of the row.
// Throughput: one seed per cycle; busy is never raised and the row advances every cycle.
// Reset: rst_n clears the valid flags of all cells at once, so no stale key is shown.
module seed_to_key_feistel
    import stkf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] seed,
    output logic        done,
    output logic [31:0] key
);

    logic  valid_chain [ROUNDS+1];
    half_t hi_chain    [ROUNDS+1];
    half_t lo_chain    [ROUNDS+1];

    // The row never stalls, so a new seed is taken in every cycle.
    assign busy = 1'b0;

    // Head of the row: the seed split into its halves.
    assign valid_chain[0] = start & ~busy;
    assign hi_chain[0]    = seed[31:16];
    assign lo_chain[0]    = seed[15:0];

    // One cell per round, each with its fixed round key.
    for (genvar i = 0; i < ROUNDS; i++)
    begin : g_round
        stkf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_chain[i]),
            .hi_in     (hi_chain[i]),
            .lo_in     (lo_chain[i]),
            .rkey      (RKEY_TABLE[i % NUM_RKEYS]),
            .valid_out (valid_chain[i+1]),
            .hi_out    (hi_chain[i+1]),
            .lo_out    (lo_chain[i+1])
        );
    end

    // Tail of the row: the finished key and its strobe.
    assign done = valid_chain[ROUNDS];
    assign key  = {hi_chain[ROUNDS], lo_chain[ROUNDS]};

endmodule

[rtl/stkf_checker.sv]
// Port-level checker for the seed-to-key transform, bound to the top level.
module stkf_checker
    import stkf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] seed,
    input logic        done,
    input logic [31:0] key
);

    logic xfer;

    assign xfer = start & ~busy;

    // The block never holds off a seed.
    a_never_busy : assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every transfer is followed by a key after the row's latency.
    a_key_follows : assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> ##ROUNDS done)
        else $error("no key after a transferred seed");

    // No key appears without a transfer the row's latency earlier.
    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(xfer, ROUNDS))
        else $error("key shown without a matching seed");

    // A transferred seed carries no unknown bits.
    a_seed_known : assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> !$isunknown(seed))
        else $error("seed transferred with unknown bits");

    // A key shown with its strobe carries no unknown bits.
    a_key_known : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(key))
        else $error("key shown with unknown bits");

endmodule

bind seed_to_key_feistel stkf_checker u_stkf_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .seed  (seed),
    .done  (done),
    .key   (key)
);

[test/seed_to_key_checker.sv]
`timescale 1ns / 1ps
// Checker for the seed-to-key transform: it predicts each key and compares it with the block's output.
module seed_to_key_checker
    import stkf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] seed,
    input  logic        done,
    input  logic [31:0] key,
    output int          failures,
    output int          outstanding,
    output int          keys_checked
);

    // Round count and size of the round-key set, kept apart from the design's own copies.
    localparam int KEY_ROUNDS  = 19;
    localparam int KEY_SET_LEN = 19;

    logic [31:0] pending_keys [$];
    int          fail_count  = 0;
    int          check_count = 0;
    int          queue_depth = 0;

    assign failures     = fail_count;
    assign outstanding  = queue_depth;
    assign keys_checked = check_count;

    // Fixed round keys, one per round.
    function automatic half_t round_key(input int idx);
        case (idx)
            0:       return 16'hb5d5;
            1:       return 16'h1741;
            2:       return 16'hfe95;
            3:       return 16'h4ad5;
            4:       return 16'h9497;
            5:       return 16'hddc5;
            6:       return 16'h3761;
            7:       return 16'h4b0d;
            8:       return 16'h5f5d;
            9:       return 16'h6b23;
            10:      return 16'hcfa9;
            11:      return 16'hc8e7;
            12:      return 16'hf209;
            13:      return 16'h4fff;
            14:      return 16'hff2b;
            15:      return 16'h4801;
            16:      return 16'h8891;
            17:      return 16'h48b9;
            default: return 16'h3607;
        endcase
    endfunction

    // Works out the key for one seed by running every Feistel round in turn.
    function automatic logic [31:0] derive_key(input logic [31:0] challenge);
        half_t hi;
        half_t lo;
        half_t mix;
        half_t rk;
        logic  par;
        hi = challenge[31:16];
        lo = challenge[15:0];
        for (int r = 0; r < KEY_ROUNDS; r++) begin
            rk  = round_key(r % KEY_SET_LEN);
            mix = lo ^ rk;
            // The parity of bits 15, 4, 2 and 1 is shifted in at the bottom.
            par = mix[15] ^ mix[4] ^ mix[2] ^ mix[1];
            mix = {mix[14:0], par};
            mix = {mix[7:0], mix[15:8]} ^ rk;
            lo  = hi;
            hi  = hi ^ mix;
        end
        return {hi, lo};
    endfunction

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // Compare each key strobe with the oldest prediction, then record any seed transfer.
    always @(posedge clk) begin
        logic [31:0] want;
        if (rst_n) begin
            if (done) begin
                if (pending_keys.size() == 0) begin
                    report($sformatf("key %h arrived with no seed outstanding", key));
                end
                else begin
                    want = pending_keys.pop_front();
                    check_count++;
                    if (key !== want)
                        report($sformatf("key %h, predicted %h", key, want));
                end
            end
            if (start && !busy)
                pending_keys.push_back(derive_key(seed));
            queue_depth = pending_keys.size();
        end
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Top of the seed-to-key testbench: clock, reset, seed stimulus and the final verdict.
module testbench;
    import stkf_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] seed;
    logic        done;
    logic [31:0] key;
    int          failures;
    int          outstanding;
    int          keys_checked;
    int          seeds_sent = 0;

    seed_to_key_feistel uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .seed  (seed),
        .done  (done),
        .key   (key)
    );

    seed_to_key_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .seed         (seed),
        .done         (done),
        .key          (key),
        .failures     (failures),
        .outstanding  (outstanding),
        .keys_checked (keys_checked)
    );

    // 100 MHz clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one seed after the given number of idle cycles and waits for its transfer.
    // Start is lowered only when there is a gap, so back-to-back seeds keep it high.
    task automatic send_seed(input logic [31:0] value, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        seed  = value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        seeds_sent++;
    endtask

    // Holds the sender off until every predicted key has been seen.
    task automatic drain;
        @(negedge clk);
        start = 1'b0;
        wait (outstanding == 0);
    endtask

    // Random seed with a bias towards zero or all-ones halves and single set bits.
    function automatic logic [31:0] pick_seed;
        logic [15:0] part;
        part = 16'($urandom_range(0, 16'hffff));
        case ($urandom_range(0, 7))
            0:       return {16'h0000, part};
            1:       return {part, 16'h0000};
            2:       return {16'hffff, part};
            3:       return {part, 16'hffff};
            4:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // Reset, directed corner seeds, then random seeds in bursts and with gaps.
    initial
    begin
        bit burst;
        rst_n = 1'b0;
        start = 1'b0;
        seed  = 32'h0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extremes of the seed and of each half, alternating patterns and single bits.
        send_seed(32'h0000_0000, 0);
        send_seed(32'hffff_ffff, 0);
        send_seed(32'h0000_ffff, $urandom_range(0, 6));
        send_seed(32'hffff_0000, 0);
        send_seed(32'h5555_5555, $urandom_range(0, 6));
        send_seed(32'haaaa_aaaa, 0);
        send_seed(32'h0000_0001, 0);
        send_seed(32'h8000_0000, $urandom_range(0, 6));
        send_seed(32'h0001_0000, 0);
        send_seed(32'h0000_8000, 0);
        send_seed(32'h7fff_ffff, $urandom_range(0, 6));
        send_seed(32'hffff_fffe, 0);
        // Low halves that hit the parity taps after the first round-key mix.
        send_seed(32'h1234_b5d5, 0);
        send_seed(32'h1234_b5c3, $urandom_range(0, 6));
        send_seed(32'h1234_35d5, 0);
        send_seed(32'h0123_4567, 0);
        send_seed(32'h89ab_cdef, 0);
        drain();

        // Random seeds in chunks of fifty; some chunks run flat out with no gaps.
        for (int chunk = 0; chunk < 31; chunk++)
        begin
            burst = ($urandom_range(0, 2) == 0);
            if (chunk == 15)
                drain();
            for (int n = 0; n < 50; n++)
                send_seed(pick_seed(), burst ? 0 : $urandom_range(0, 6));
        end

        drain();
        repeat (ROUNDS + 6) @(posedge clk);
        $display("Sent %0d seeds (corner values, biased random, bursts and gaps); %0d keys checked.",
                 seeds_sent, keys_checked);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Safety net in case the run stalls.
    initial
    begin
        #2_000_000;
        $display("Timeout: the run did not complete");
        $display("Verification failed");
        $finish;
    end

endmodule
